[rtl/kf2d_pkg.sv]
package kf2d_pkg;

  // Fixed port widths
  localparam int FUNC_W     = 2;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NOISE_W    = 31;
  localparam int DT_W       = 16;
  localparam int TS_FRAC    = 16;

  // Parameter defaults
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Register reset values
  localparam logic [NOISE_W-1:0] RST_PROC_NOISE = NOISE_W'(6554);
  localparam logic [NOISE_W-1:0] RST_MEAS_NOISE = NOISE_W'(6554);
  localparam logic [NOISE_W-1:0] RST_INIT_ERR   = NOISE_W'(65536);
  localparam logic [VAL_W-1:0]   RST_INIT_X     = '0;
  localparam logic [VAL_W-1:0]   RST_INIT_Y     = '0;
  localparam logic [DT_W-1:0]    RST_TIME_STEP  = DT_W'(6554);

  typedef enum logic [FUNC_W-1:0] {
    FN_PREDICT = 2'd0,
    FN_UPDATE  = 2'd1,
    FN_REINIT  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_NOISE = 3'd0,
    CFG_MEAS_NOISE = 3'd1,
    CFG_INIT_ERR   = 3'd2,
    CFG_INIT_X     = 3'd3,
    CFG_INIT_Y     = 3'd4,
    CFG_TIME_STEP  = 3'd5
  } cfg_idx_t;

  // Micro-operations of the sequencer
  typedef enum logic [3:0] {
    U_END, U_MAC, U_PRED_Q, U_LOAD_INIT, U_PREP_S,
    U_CHECK_DET, U_DIV, U_RESID, U_IK, U_COPY_P
  } uop_kind_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_DT, SRC_VX, SRC_VY,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3,
    SRC_S0, SRC_S1, SRC_S2, SRC_S3,
    SRC_INV0, SRC_INV1, SRC_INV2, SRC_INV3,
    SRC_K0, SRC_K1, SRC_K2, SRC_K3,
    SRC_IK0, SRC_IK1, SRC_IK2, SRC_IK3,
    SRC_YX, SRC_YY
  } src_t;

  typedef enum logic [1:0] {INIT_ZERO, INIT_PX, INIT_PY} init_t;

  typedef enum logic [3:0] {
    DST_DET, DST_K0, DST_K1, DST_K2, DST_K3,
    DST_NP0, DST_NP1, DST_NP2, DST_NP3, DST_PX, DST_PY
  } dst_t;

  typedef struct packed {
    uop_kind_t  kind;
    src_t       a0;
    src_t       b0;
    src_t       a1;
    src_t       b1;
    init_t      init;
    logic       sub;
    logic       ts;
    dst_t       dst;
    logic [1:0] idx;
  } uop_t;

  typedef struct packed {
    logic       exec;
    uop_t       uop;
    logic [1:0] ph;
    logic       capture;
    logic       div_start;
    logic       load_out;
    logic       singular;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } status_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_PREDICT = 5'd0;
  localparam logic [PC_W-1:0] PC_REINIT  = 5'd4;
  localparam logic [PC_W-1:0] PC_NOP     = 5'd6;
  localparam logic [PC_W-1:0] PC_UPDATE  = 5'd7;

  function automatic uop_t uop_plain(uop_kind_t k, logic [1:0] idx);
    uop_t u;
    u.kind = k;
    u.a0   = SRC_ZERO;
    u.b0   = SRC_ZERO;
    u.a1   = SRC_ZERO;
    u.b1   = SRC_ZERO;
    u.init = INIT_ZERO;
    u.sub  = 1'b0;
    u.ts   = 1'b0;
    u.dst  = DST_DET;
    u.idx  = idx;
    return u;
  endfunction

  // acc = init + a0*b0 +/- a1*b1, saturated into dst
  function automatic uop_t uop_mac(src_t a0, src_t b0, src_t a1, src_t b1,
                                   init_t init, logic sub, logic ts, dst_t dst);
    uop_t u;
    u      = uop_plain(U_MAC, 2'd0);
    u.a0   = a0;
    u.b0   = b0;
    u.a1   = a1;
    u.b1   = b1;
    u.init = init;
    u.sub  = sub;
    u.ts   = ts;
    u.dst  = dst;
    return u;
  endfunction

  // Microprogram: predict, reinit, no-op and update sequences
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = uop_mac(SRC_VX, SRC_DT, SRC_ZERO, SRC_ZERO, INIT_PX, 1'b0, 1'b1, DST_PX);
      5'd1:  u = uop_mac(SRC_VY, SRC_DT, SRC_ZERO, SRC_ZERO, INIT_PY, 1'b0, 1'b1, DST_PY);
      5'd2:  u = uop_plain(U_PRED_Q, 2'd0);
      5'd4:  u = uop_plain(U_LOAD_INIT, 2'd0);
      5'd7:  u = uop_plain(U_PREP_S, 2'd0);
      5'd8:  u = uop_mac(SRC_S0, SRC_S3, SRC_S1, SRC_S2, INIT_ZERO, 1'b1, 1'b0, DST_DET);
      5'd9:  u = uop_plain(U_CHECK_DET, 2'd0);
      5'd10: u = uop_plain(U_DIV, 2'd0);
      5'd11: u = uop_plain(U_DIV, 2'd1);
      5'd12: u = uop_plain(U_DIV, 2'd2);
      5'd13: u = uop_plain(U_DIV, 2'd3);
      5'd14: u = uop_mac(SRC_P0, SRC_INV0, SRC_P1, SRC_INV2, INIT_ZERO, 1'b0, 1'b0, DST_K0);
      5'd15: u = uop_mac(SRC_P0, SRC_INV1, SRC_P1, SRC_INV3, INIT_ZERO, 1'b0, 1'b0, DST_K1);
      5'd16: u = uop_mac(SRC_P2, SRC_INV0, SRC_P3, SRC_INV2, INIT_ZERO, 1'b0, 1'b0, DST_K2);
      5'd17: u = uop_mac(SRC_P2, SRC_INV1, SRC_P3, SRC_INV3, INIT_ZERO, 1'b0, 1'b0, DST_K3);
      5'd18: u = uop_plain(U_RESID, 2'd0);
      5'd19: u = uop_mac(SRC_K0, SRC_YX, SRC_K1, SRC_YY, INIT_PX, 1'b0, 1'b0, DST_PX);
      5'd20: u = uop_mac(SRC_K2, SRC_YX, SRC_K3, SRC_YY, INIT_PY, 1'b0, 1'b0, DST_PY);
      5'd21: u = uop_plain(U_IK, 2'd0);
      5'd22: u = uop_mac(SRC_IK0, SRC_P0, SRC_IK1, SRC_P2, INIT_ZERO, 1'b0, 1'b0, DST_NP0);
      5'd23: u = uop_mac(SRC_IK0, SRC_P1, SRC_IK1, SRC_P3, INIT_ZERO, 1'b0, 1'b0, DST_NP1);
      5'd24: u = uop_mac(SRC_IK2, SRC_P0, SRC_IK3, SRC_P2, INIT_ZERO, 1'b0, 1'b0, DST_NP2);
      5'd25: u = uop_mac(SRC_IK2, SRC_P1, SRC_IK3, SRC_P3, INIT_ZERO, 1'b0, 1'b0, DST_NP3);
      5'd26: u = uop_plain(U_COPY_P, 2'd0);
      default: u = uop_plain(U_END, 2'd0);
    endcase
    return u;
  endfunction

endpackage

[rtl/kf2d_if.sv]
// Input item channel
interface kf2d_in_if;
  logic                                valid;
  logic                                ready;
  logic [kf2d_pkg::FUNC_W-1:0]         func;
  logic signed [kf2d_pkg::VAL_W-1:0]   value_x;
  logic signed [kf2d_pkg::VAL_W-1:0]   value_y;
  modport source (output valid, func, value_x, value_y, input ready);
  modport sink   (input valid, func, value_x, value_y, output ready);
endinterface

// Result channel
interface kf2d_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kf2d_pkg::VAL_W-1:0]   est_x;
  logic signed [kf2d_pkg::VAL_W-1:0]   est_y;
  logic signed [kf2d_pkg::VAL_W-1:0]   var_x;
  logic signed [kf2d_pkg::VAL_W-1:0]   var_y;
  logic                                singular;
  modport source (output valid, est_x, est_y, var_x, var_y, singular, input ready);
  modport sink   (input valid, est_x, est_y, var_x, var_y, singular, output ready);
endinterface

// Configuration write channel
interface kf2d_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [kf2d_pkg::CFG_IDX_W-1:0]       index;
  logic [kf2d_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/kf2d_div.sv]
// Restoring divider, one quotient bit per cycle, truncates toward zero
module kf2d_div #(
  parameter int W = kf2d_pkg::DATA_WIDTH_DEF,
  parameter int F = kf2d_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [W+F:0]   num,
  input  logic signed [W-1:0]   den,
  output logic                  done,
  output logic signed [W+F:0]   quo
);

  localparam int NMAG = W + F;
  localparam int CW   = $clog2(NMAG + 1);

  logic [NMAG-1:0] nm_r;
  logic [W-1:0]    dm_r;
  logic [W-1:0]    rem_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;

  logic signed [W+F:0] num_abs;
  logic signed [W:0]   den_x;
  logic signed [W:0]   den_abs;
  logic [W:0]          rem_sh;
  logic                q_bit;
  logic [W:0]          rem_sub;

  always_comb begin
    num_abs = num[W+F] ? -num : num;
    den_x   = (W+1)'(den);
    den_abs = den_x[W] ? -den_x : den_x;
    rem_sh  = {rem_r, nm_r[NMAG-1]};
    q_bit   = rem_sh >= {1'b0, dm_r};
    rem_sub = rem_sh - {1'b0, dm_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NMAG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // shift/subtract datapath; quotient bits shift into the numerator register
  always_ff @(posedge clk) begin
    if (start) begin
      nm_r  <= num_abs[NMAG-1:0];
      dm_r  <= den_abs[W-1:0];
      rem_r <= '0;
      neg_r <= num[W+F] ^ den[W-1];
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
      nm_r  <= {nm_r[NMAG-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, nm_r}) : $signed({1'b0, nm_r});

endmodule

[rtl/kf2d_dp.sv]
// Filter datapath: state, configuration, shared multiplier/accumulator, divider
module kf2d_dp #(
  parameter int DATA_WIDTH = kf2d_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kf2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kf2d_pkg::cmd_t                      cmd,
  output kf2d_pkg::status_t                   status,
  input  logic signed [kf2d_pkg::VAL_W-1:0]   in_value_x,
  input  logic signed [kf2d_pkg::VAL_W-1:0]   in_value_y,
  input  logic                                cfg_valid,
  input  logic [kf2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kf2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic signed [kf2d_pkg::VAL_W-1:0]   out_est_x,
  output logic signed [kf2d_pkg::VAL_W-1:0]   out_est_y,
  output logic signed [kf2d_pkg::VAL_W-1:0]   out_var_x,
  output logic signed [kf2d_pkg::VAL_W-1:0]   out_var_y,
  output logic                                out_singular
);

  localparam int W    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OW   = W + 1;
  localparam int XW   = (2*OW + 1 > W + F + 2) ? 2*OW + 1 : W + F + 2;
  localparam int NUMW = W + F + 1;

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[W-1:0];
    end
    return v[W-1:0];
  endfunction

  localparam logic signed [W-1:0] ONE_S  = sat_w(XW'(1) <<< F);
  localparam logic signed [W-1:0] RST_E  = sat_w($signed(XW'(kf2d_pkg::RST_INIT_ERR)));
  localparam logic signed [W-1:0] RST_PX = sat_w(XW'($signed(kf2d_pkg::RST_INIT_X)));
  localparam logic signed [W-1:0] RST_PY = sat_w(XW'($signed(kf2d_pkg::RST_INIT_Y)));

  // configuration registers
  logic [kf2d_pkg::NOISE_W-1:0] q_cfg_r, r_cfg_r, e_cfg_r;
  logic [kf2d_pkg::VAL_W-1:0]   ix_cfg_r, iy_cfg_r;
  logic [kf2d_pkg::DT_W-1:0]    dt_cfg_r;

  // filter state
  logic signed [W-1:0] px_r, py_r;
  logic signed [W-1:0] p_r [4];

  // working registers
  logic signed [W-1:0]    s_r [4];
  logic signed [W-1:0]    inv_r [4];
  logic signed [W-1:0]    k_r [4];
  logic signed [W-1:0]    ik_r [4];
  logic signed [W-1:0]    np_r [4];
  logic signed [W-1:0]    det_r, yx_r, yy_r, vx_r, vy_r;
  logic signed [2*OW-1:0] prod_r;
  logic signed [XW-1:0]   acc_r;

  logic signed [kf2d_pkg::VAL_W-1:0] est_x_r, est_y_r, var_x_r, var_y_r;
  logic                              sing_r;

  kf2d_pkg::uop_t       uop;
  kf2d_pkg::src_t       sel_a, sel_b;
  logic signed [OW-1:0] mop_a, mop_b;
  logic signed [2*OW-1:0] mul_w;
  logic signed [XW-1:0] shp, acc_init, num_x;
  logic signed [NUMW-1:0] div_num;
  logic                 div_done;
  logic signed [NUMW-1:0] div_quo;
  logic signed [W-1:0]  q_s, r_s, e_s;
  logic                 mac_go, mac_last;

  function automatic logic signed [OW-1:0] src_val(input kf2d_pkg::src_t s);
    case (s)
      kf2d_pkg::SRC_DT:   return $signed(OW'(dt_cfg_r));
      kf2d_pkg::SRC_VX:   return OW'(vx_r);
      kf2d_pkg::SRC_VY:   return OW'(vy_r);
      kf2d_pkg::SRC_P0:   return OW'(p_r[0]);
      kf2d_pkg::SRC_P1:   return OW'(p_r[1]);
      kf2d_pkg::SRC_P2:   return OW'(p_r[2]);
      kf2d_pkg::SRC_P3:   return OW'(p_r[3]);
      kf2d_pkg::SRC_S0:   return OW'(s_r[0]);
      kf2d_pkg::SRC_S1:   return OW'(s_r[1]);
      kf2d_pkg::SRC_S2:   return OW'(s_r[2]);
      kf2d_pkg::SRC_S3:   return OW'(s_r[3]);
      kf2d_pkg::SRC_INV0: return OW'(inv_r[0]);
      kf2d_pkg::SRC_INV1: return OW'(inv_r[1]);
      kf2d_pkg::SRC_INV2: return OW'(inv_r[2]);
      kf2d_pkg::SRC_INV3: return OW'(inv_r[3]);
      kf2d_pkg::SRC_K0:   return OW'(k_r[0]);
      kf2d_pkg::SRC_K1:   return OW'(k_r[1]);
      kf2d_pkg::SRC_K2:   return OW'(k_r[2]);
      kf2d_pkg::SRC_K3:   return OW'(k_r[3]);
      kf2d_pkg::SRC_IK0:  return OW'(ik_r[0]);
      kf2d_pkg::SRC_IK1:  return OW'(ik_r[1]);
      kf2d_pkg::SRC_IK2:  return OW'(ik_r[2]);
      kf2d_pkg::SRC_IK3:  return OW'(ik_r[3]);
      kf2d_pkg::SRC_YX:   return OW'(yx_r);
      kf2d_pkg::SRC_YY:   return OW'(yy_r);
      default:            return '0;
    endcase
  endfunction

  // operand selection, multiplier and accumulator inputs
  always_comb begin
    uop      = cmd.uop;
    sel_a    = (cmd.ph == 2'd0) ? uop.a0 : uop.a1;
    sel_b    = (cmd.ph == 2'd0) ? uop.b0 : uop.b1;
    mop_a    = src_val(sel_a);
    mop_b    = src_val(sel_b);
    mul_w    = (2*OW)'(mop_a) * (2*OW)'(mop_b);
    shp      = uop.ts ? (XW'(prod_r) >>> kf2d_pkg::TS_FRAC) : (XW'(prod_r) >>> F);
    case (uop.init)
      kf2d_pkg::INIT_PX: acc_init = XW'(px_r);
      kf2d_pkg::INIT_PY: acc_init = XW'(py_r);
      default:           acc_init = '0;
    endcase
    case (uop.idx)
      2'd0:    num_x = XW'(s_r[3]);
      2'd1:    num_x = -XW'(s_r[1]);
      2'd2:    num_x = -XW'(s_r[2]);
      default: num_x = XW'(s_r[0]);
    endcase
    div_num  = NUMW'(num_x <<< F);
    q_s      = sat_w($signed(XW'(q_cfg_r)));
    r_s      = sat_w($signed(XW'(r_cfg_r)));
    e_s      = sat_w($signed(XW'(e_cfg_r)));
    mac_go   = cmd.exec && (uop.kind == kf2d_pkg::U_MAC);
    mac_last = mac_go && (cmd.ph == 2'd3);
  end

  kf2d_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cfg_r  <= kf2d_pkg::RST_PROC_NOISE;
      r_cfg_r  <= kf2d_pkg::RST_MEAS_NOISE;
      e_cfg_r  <= kf2d_pkg::RST_INIT_ERR;
      ix_cfg_r <= kf2d_pkg::RST_INIT_X;
      iy_cfg_r <= kf2d_pkg::RST_INIT_Y;
      dt_cfg_r <= kf2d_pkg::RST_TIME_STEP;
      px_r     <= RST_PX;
      py_r     <= RST_PY;
      p_r[0]   <= RST_E;
      p_r[1]   <= '0;
      p_r[2]   <= '0;
      p_r[3]   <= RST_E;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          kf2d_pkg::CFG_PROC_NOISE: q_cfg_r  <= cfg_data[kf2d_pkg::NOISE_W-1:0];
          kf2d_pkg::CFG_MEAS_NOISE: r_cfg_r  <= cfg_data[kf2d_pkg::NOISE_W-1:0];
          kf2d_pkg::CFG_INIT_ERR:   e_cfg_r  <= cfg_data[kf2d_pkg::NOISE_W-1:0];
          kf2d_pkg::CFG_INIT_X:     ix_cfg_r <= cfg_data;
          kf2d_pkg::CFG_INIT_Y:     iy_cfg_r <= cfg_data;
          kf2d_pkg::CFG_TIME_STEP:  dt_cfg_r <= cfg_data[kf2d_pkg::DT_W-1:0];
          default: ;
        endcase
      end
      if (mac_last && uop.dst == kf2d_pkg::DST_PX) begin
        px_r <= sat_w(acc_r);
      end
      if (mac_last && uop.dst == kf2d_pkg::DST_PY) begin
        py_r <= sat_w(acc_r);
      end
      if (cmd.exec) begin
        case (uop.kind)
          kf2d_pkg::U_PRED_Q: begin
            p_r[0] <= sat_w(XW'(p_r[0]) + XW'(q_s));
            p_r[3] <= sat_w(XW'(p_r[3]) + XW'(q_s));
          end
          kf2d_pkg::U_LOAD_INIT: begin
            px_r   <= sat_w(XW'($signed(ix_cfg_r)));
            py_r   <= sat_w(XW'($signed(iy_cfg_r)));
            p_r[0] <= e_s;
            p_r[1] <= '0;
            p_r[2] <= '0;
            p_r[3] <= e_s;
          end
          kf2d_pkg::U_COPY_P: begin
            for (int i = 0; i < 4; i++) begin
              p_r[i] <= np_r[i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vx_r <= sat_w(XW'(in_value_x));
      vy_r <= sat_w(XW'(in_value_y));
    end
    if (mac_go) begin
      case (cmd.ph)
        2'd0: begin
          acc_r  <= acc_init;
          prod_r <= mul_w;
        end
        2'd1: begin
          acc_r  <= acc_r + shp;
          prod_r <= mul_w;
        end
        2'd2: acc_r <= uop.sub ? (acc_r - shp) : (acc_r + shp);
        default: begin
          case (uop.dst)
            kf2d_pkg::DST_DET: det_r    <= sat_w(acc_r);
            kf2d_pkg::DST_K0:  k_r[0]   <= sat_w(acc_r);
            kf2d_pkg::DST_K1:  k_r[1]   <= sat_w(acc_r);
            kf2d_pkg::DST_K2:  k_r[2]   <= sat_w(acc_r);
            kf2d_pkg::DST_K3:  k_r[3]   <= sat_w(acc_r);
            kf2d_pkg::DST_NP0: np_r[0]  <= sat_w(acc_r);
            kf2d_pkg::DST_NP1: np_r[1]  <= sat_w(acc_r);
            kf2d_pkg::DST_NP2: np_r[2]  <= sat_w(acc_r);
            kf2d_pkg::DST_NP3: np_r[3]  <= sat_w(acc_r);
            default: ;
          endcase
        end
      endcase
    end
    if (cmd.exec) begin
      case (uop.kind)
        kf2d_pkg::U_PREP_S: begin
          s_r[0] <= sat_w(XW'(p_r[0]) + XW'(r_s));
          s_r[1] <= p_r[1];
          s_r[2] <= p_r[2];
          s_r[3] <= sat_w(XW'(p_r[3]) + XW'(r_s));
        end
        kf2d_pkg::U_DIV: begin
          if (div_done) begin
            inv_r[uop.idx] <= sat_w(XW'(div_quo));
          end
        end
        kf2d_pkg::U_RESID: begin
          yx_r <= sat_w(XW'(vx_r) - XW'(px_r));
          yy_r <= sat_w(XW'(vy_r) - XW'(py_r));
        end
        kf2d_pkg::U_IK: begin
          ik_r[0] <= sat_w(XW'(ONE_S) - XW'(k_r[0]));
          ik_r[1] <= sat_w(-XW'(k_r[1]));
          ik_r[2] <= sat_w(-XW'(k_r[2]));
          ik_r[3] <= sat_w(XW'(ONE_S) - XW'(k_r[3]));
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      est_x_r <= kf2d_pkg::VAL_W'(px_r);
      est_y_r <= kf2d_pkg::VAL_W'(py_r);
      var_x_r <= kf2d_pkg::VAL_W'(p_r[0]);
      var_y_r <= kf2d_pkg::VAL_W'(p_r[3]);
      sing_r  <= cmd.singular;
    end
  end

  assign status.det_zero = (det_r == '0);
  assign status.div_done = div_done;
  assign out_est_x    = est_x_r;
  assign out_est_y    = est_y_r;
  assign out_var_x    = var_x_r;
  assign out_var_y    = var_y_r;
  assign out_singular = sing_r;

endmodule

[rtl/kf2d_ctrl.sv]
// Sequencer: steps the microprogram and runs both handshakes
module kf2d_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kf2d_pkg::FUNC_W-1:0]    in_func,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kf2d_pkg::cmd_t                 cmd,
  input  kf2d_pkg::status_t              status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [kf2d_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [1:0]                 ph_r, ph_nxt;
  logic                       sing_r, sing_nxt;
  logic                       out_valid_r, out_valid_nxt;
  kf2d_pkg::uop_t             uop;
  logic [kf2d_pkg::PC_W-1:0]  pc_inc;

  always_comb begin
    uop           = kf2d_pkg::uop_rom(pc_r);
    pc_inc        = pc_r + kf2d_pkg::PC_W'(1);
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    ph_nxt        = ph_r;
    sing_nxt      = sing_r;
    cmd.exec      = (state_r == ST_EXEC);
    cmd.uop       = uop;
    cmd.ph        = ph_r;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.singular  = sing_r;
    in_ready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          sing_nxt    = 1'b0;
          ph_nxt      = 2'd0;
          state_nxt   = ST_EXEC;
          unique case (in_func)
            kf2d_pkg::FN_PREDICT: pc_nxt = kf2d_pkg::PC_PREDICT;
            kf2d_pkg::FN_UPDATE:  pc_nxt = kf2d_pkg::PC_UPDATE;
            kf2d_pkg::FN_REINIT:  pc_nxt = kf2d_pkg::PC_REINIT;
            default:              pc_nxt = kf2d_pkg::PC_NOP;
          endcase
        end
      end
      ST_EXEC: begin
        unique case (uop.kind)
          kf2d_pkg::U_MAC: begin
            if (ph_r == 2'd3) begin
              ph_nxt = 2'd0;
              pc_nxt = pc_inc;
            end else begin
              ph_nxt = ph_r + 2'd1;
            end
          end
          kf2d_pkg::U_DIV: begin
            if (ph_r == 2'd0) begin
              cmd.div_start = 1'b1;
              ph_nxt        = 2'd1;
            end else if (status.div_done) begin
              ph_nxt = 2'd0;
              pc_nxt = pc_inc;
            end
          end
          kf2d_pkg::U_CHECK_DET: begin
            // zero determinant: skip the rest of the update
            if (status.det_zero) begin
              sing_nxt = 1'b1;
              pc_nxt   = kf2d_pkg::PC_NOP;
            end else begin
              pc_nxt = pc_inc;
            end
          end
          kf2d_pkg::U_END: state_nxt = ST_DONE;
          default:         pc_nxt = pc_inc;
        endcase
      end
      ST_DONE: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ph_r        <= '0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ph_r        <= ph_nxt;
      sing_r      <= sing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/kalman_filter_2d_position.sv]
// Two-axis position Kalman filter, signed fixed point (FRAC_BITS fraction bits).
// Channels: in_if carries one transaction per item (func, value_x, value_y);
// func 0 predicts with value_x/value_y as velocity, 1 corrects with them as a
// measurement, 2 reloads state from the registers, 3 only reports the state.
// out_if returns one transaction per item: position, covariance diagonal and
// the singular flag raised when an update met a zero determinant.
// cfg_if writes the six registers at any time, always ready; write only while idle.
// The update's work is dominated by the four 1-bit-per-cycle divisions of the
// inverse; the rest is one shared multiplier stepped by microcode, with the
// datapath width W = DATA_WIDTH capped at 32. A zero determinant cuts the update
// short. One item is in work at a time: the next transaction is accepted the
// cycle after the result is loaded into the output register, even if the
// receiver has not yet taken it.
// When the receiver stalls the result holds and the next finished item waits.
// Reset (rst_n low, synchronous) restores register defaults and loads position
// and covariance from them; no result is pending after reset.
module kalman_filter_2d_position #(
  parameter int DATA_WIDTH = kf2d_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kf2d_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  kf2d_in_if.sink        in_if,
  kf2d_out_if.source     out_if,
  kf2d_cfg_if.sink       cfg_if
);

  kf2d_pkg::cmd_t    cmd;
  kf2d_pkg::status_t status;

  assign cfg_if.ready = 1'b1;

  kf2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_func   (in_if.func),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .status    (status)
  );

  kf2d_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_value_x   (in_if.value_x),
    .in_value_y   (in_if.value_y),
    .cfg_valid    (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .out_est_x    (out_if.est_x),
    .out_est_y    (out_if.est_y),
    .out_var_x    (out_if.var_x),
    .out_var_y    (out_if.var_y),
    .out_singular (out_if.singular)
  );

endmodule
